[src/htf_pkg.sv]
// ----------------------------------------------------------------------------
// htf_pkg
// Shared types, constants and tables of the request framer: payload beats,
// byte classes between front and back, status and register codes.
// ----------------------------------------------------------------------------
package htf_pkg;

	// counter width of byte count and expected message total
	localparam int COUNT_WIDTH = 32;

	localparam int KEY_LEN  = 15;
	localparam int KP_W     = $clog2(KEY_LEN);
	localparam int HLIM_W   = 21;
	localparam int BLIM_W   = 25;
	localparam int LIMIT_W  = BLIM_W + 1;
	localparam int VAL_W    = 32;
	localparam int CMP_W    = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
	localparam int MSG_W    = (COUNT_WIDTH > VAL_W) ? COUNT_WIDTH : VAL_W;
	localparam int SUM_W    = MSG_W + 1;
	localparam int PROD_W   = VAL_W + 4;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [VAL_W-1:0]       VAL_MAX = '1;

	localparam logic [HLIM_W-1:0] DEFAULT_HEADER_LIMIT = HLIM_W'(8192);
	localparam logic [BLIM_W-1:0] DEFAULT_BODY_LIMIT   = BLIM_W'(1048576);

	// register indexes
	localparam logic REG_HEADER_LIMIT = 1'b0;
	localparam logic REG_BODY_LIMIT   = 1'b1;

	// input kinds
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_MORE      = 2'd0;
	localparam logic [1:0] STATUS_COMPLETE  = 2'd1;
	localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

	// special bytes
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	// header keyword, lower case
	localparam logic [7:0] KEYWORD [KEY_LEN] = '{
		8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
		8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
	};

	// length field scan phase
	typedef enum logic [1:0] {
		PH_SEARCH   = 2'd0,
		PH_SKIP     = 2'd1,
		PH_DIGITS   = 2'd2,
		PH_FINISHED = 2'd3
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} request_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] message_length;
		logic [VAL_W-1:0] body_length;
	} result_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic               restart;
		logic               digit;
		logic [3:0]         digit_val;
		logic               space;
		logic               cr;
		logic               lf;
		logic [KEY_LEN-1:0] match;
	} class_t;

endpackage

[src/htf_classify.sv]
// ----------------------------------------------------------------------------
// htf_classify
// Front end: folds the byte to lower case and marks digit, space, CR, LF and
// every keyword position that the byte would match.
// ----------------------------------------------------------------------------
module htf_classify (
	input  htf_pkg::request_t request,
	output htf_pkg::class_t   cls
);

	logic [7:0] lc;

	// lower-case fold
	always_comb begin
		if (request.byte_value >= htf_pkg::CHAR_UPPER_A &&
				request.byte_value <= htf_pkg::CHAR_UPPER_Z) begin
			lc = request.byte_value + htf_pkg::CASE_OFFSET;
		end else begin
			lc = request.byte_value;
		end
	end

	// byte classes
	always_comb begin
		cls.restart   = (request.kind == htf_pkg::KIND_RESTART);
		cls.digit     = (request.byte_value >= htf_pkg::CHAR_ZERO) &&
				(request.byte_value <= htf_pkg::CHAR_NINE);
		cls.digit_val = 4'(request.byte_value - htf_pkg::CHAR_ZERO);
		cls.space     = (request.byte_value == htf_pkg::CHAR_SPACE);
		cls.cr        = (request.byte_value == htf_pkg::CHAR_CR);
		cls.lf        = (request.byte_value == htf_pkg::CHAR_LF);
		for (int i = 0; i < htf_pkg::KEY_LEN; i++) begin
			cls.match[i] = (lc == htf_pkg::KEYWORD[i]);
		end
	end

endmodule

[src/htf_class_queue.sv]
// ----------------------------------------------------------------------------
// htf_class_queue
// Two-entry queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module htf_class_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  htf_pkg::class_t din,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output htf_pkg::class_t dout
);

	htf_pkg::class_t mem_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

[src/htf_engine.sv]
// ----------------------------------------------------------------------------
// htf_engine
// Back end: keeps the message state, tracks the keyword, length value and
// header terminator, decides completion or overflow and queues one result
// beat per byte.
// ----------------------------------------------------------------------------
module htf_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  htf_pkg::class_t              cls,
	input  logic                         cls_empty,
	output logic                         cls_pop,
	input  logic [htf_pkg::LIMIT_W-1:0]  limit,
	output logic                         empty,
	input  logic                         pop,
	output htf_pkg::result_t             result
);

	localparam int CW = htf_pkg::COUNT_WIDTH;

	// message state
	logic [CW-1:0]               bc_q;
	logic [1:0]                  tp_q;
	logic                        hd_q;
	logic [CW-1:0]               total_q;
	logic [htf_pkg::KP_W-1:0]    kp_q;
	htf_pkg::phase_t             ph_q;
	logic [htf_pkg::VAL_W-1:0]   lv_q;

	// next values
	logic [CW-1:0]               bc_n;
	logic [1:0]                  tp_n;
	logic                        hd_n;
	logic [CW-1:0]               total_n;
	logic [htf_pkg::KP_W-1:0]    kp_n;
	htf_pkg::phase_t             ph_n;
	logic [htf_pkg::VAL_W-1:0]   lv_n;

	// per-byte evaluation
	logic                        take;
	logic [CW-1:0]               bc_inc;
	logic                        kw_hit;
	logic [htf_pkg::KP_W:0]      kp_adv;
	logic [htf_pkg::KP_W-1:0]    kp_scan;
	htf_pkg::phase_t             ph_scan;
	logic [htf_pkg::VAL_W-1:0]   lv_scan;
	logic [htf_pkg::PROD_W-1:0]  lv_prod;
	logic [1:0]                  tp_scan;
	logic                        term_end;
	logic [htf_pkg::SUM_W-1:0]   total_sum;
	logic [CW-1:0]               total_new;
	logic [CW-1:0]               total_eff;
	logic [htf_pkg::MSG_W-1:0]   total_ext;
	logic                        too_large;
	logic                        complete;
	htf_pkg::result_t            res_d;

	// result queue
	htf_pkg::result_t            res_mem_q [2];
	logic                        res_wptr_q;
	logic                        res_rptr_q;
	logic [1:0]                  res_count_q;
	logic                        res_full;
	logic                        res_pop;

	assign res_full = (res_count_q == 2'd2);
	assign take     = !cls_empty && !res_full;
	assign cls_pop  = take;
	assign empty    = (res_count_q == 2'd0);
	assign res_pop  = pop && !empty;
	assign result   = res_mem_q[res_rptr_q];

	// saturating byte count
	assign bc_inc = (bc_q < htf_pkg::CNT_MAX) ? bc_q + CW'(1) : bc_q;

	// keyword tracking
	always_comb begin
		kw_hit = (32'(kp_q) < htf_pkg::KEY_LEN) && cls.match[kp_q];
		if (kw_hit) begin
			kp_adv = {1'b0, kp_q} + (htf_pkg::KP_W+1)'(1);
		end else begin
			kp_adv = {{htf_pkg::KP_W{1'b0}}, cls.match[0]};
		end
		kp_scan = kp_q;
		if (ph_q == htf_pkg::PH_SEARCH) begin
			if (32'(kp_adv) >= htf_pkg::KEY_LEN) begin
				kp_scan = '0;
			end else begin
				kp_scan = kp_adv[htf_pkg::KP_W-1:0];
			end
		end
	end

	// length scan phase
	always_comb begin
		unique case (ph_q)
			htf_pkg::PH_SEARCH: begin
				if (32'(kp_adv) >= htf_pkg::KEY_LEN) begin
					ph_scan = htf_pkg::PH_SKIP;
				end else begin
					ph_scan = htf_pkg::PH_SEARCH;
				end
			end
			htf_pkg::PH_SKIP: begin
				if (cls.digit) begin
					ph_scan = htf_pkg::PH_DIGITS;
				end else if (cls.space) begin
					ph_scan = htf_pkg::PH_SKIP;
				end else begin
					ph_scan = htf_pkg::PH_FINISHED;
				end
			end
			htf_pkg::PH_DIGITS: begin
				if (cls.digit) begin
					ph_scan = htf_pkg::PH_DIGITS;
				end else begin
					ph_scan = htf_pkg::PH_FINISHED;
				end
			end
			htf_pkg::PH_FINISHED: begin
				ph_scan = htf_pkg::PH_FINISHED;
			end
			default: begin
				ph_scan = htf_pkg::PH_FINISHED;
			end
		endcase
	end

	// decimal accumulation, saturating
	always_comb begin
		lv_prod = htf_pkg::PROD_W'(lv_q) * htf_pkg::PROD_W'(10) +
				htf_pkg::PROD_W'(cls.digit_val);
		lv_scan = lv_q;
		if ((ph_q == htf_pkg::PH_SKIP || ph_q == htf_pkg::PH_DIGITS) && cls.digit) begin
			if (|lv_prod[htf_pkg::PROD_W-1:htf_pkg::VAL_W]) begin
				lv_scan = htf_pkg::VAL_MAX;
			end else begin
				lv_scan = lv_prod[htf_pkg::VAL_W-1:0];
			end
		end
	end

	// header terminator
	always_comb begin
		term_end = 1'b0;
		priority if (cls.cr) begin
			tp_scan = (tp_q == 2'd2) ? 2'd3 : 2'd1;
		end else if (cls.lf && tp_q == 2'd1) begin
			tp_scan = 2'd2;
		end else if (cls.lf && tp_q == 2'd3) begin
			tp_scan  = 2'd0;
			term_end = 1'b1;
		end else begin
			tp_scan = 2'd0;
		end
	end

	// expected total, header length plus content length; the terminating
	// byte is never a digit, so the stored value is already final
	always_comb begin
		total_sum = htf_pkg::SUM_W'(bc_inc) + htf_pkg::SUM_W'(lv_q);
		if (total_sum > htf_pkg::SUM_W'(htf_pkg::CNT_MAX)) begin
			total_new = htf_pkg::CNT_MAX;
		end else begin
			total_new = total_sum[CW-1:0];
		end
	end

	// overflow and completion decision
	always_comb begin
		if (hd_q) begin
			lv_n      = lv_q;
			total_eff = total_q;
		end else begin
			lv_n      = lv_scan;
			total_eff = total_new;
		end
		total_ext = htf_pkg::MSG_W'(total_eff);
		too_large = htf_pkg::CMP_W'(bc_inc) > htf_pkg::CMP_W'(limit);
		complete  = !too_large && (hd_q || term_end) && (bc_inc >= total_eff);
	end

	// next state
	always_comb begin
		bc_n    = bc_q;
		tp_n    = tp_q;
		hd_n    = hd_q;
		total_n = total_q;
		kp_n    = kp_q;
		ph_n    = ph_q;
		if (take) begin
			if (cls.restart || complete) begin
				bc_n    = '0;
				tp_n    = 2'd0;
				hd_n    = 1'b0;
				total_n = '0;
				kp_n    = '0;
				ph_n    = htf_pkg::PH_SEARCH;
			end else begin
				bc_n = bc_inc;
				if (!hd_q) begin
					tp_n = tp_scan;
					kp_n = kp_scan;
					ph_n = ph_scan;
					if (term_end) begin
						hd_n    = 1'b1;
						total_n = total_new;
					end
				end
			end
		end
	end

	// result beat
	always_comb begin
		res_d.status         = htf_pkg::STATUS_MORE;
		res_d.message_length = '0;
		res_d.body_length    = lv_n;
		if (cls.restart) begin
			res_d.body_length = '0;
		end else if (too_large) begin
			res_d.status = htf_pkg::STATUS_TOO_LARGE;
		end else if (complete) begin
			res_d.status = htf_pkg::STATUS_COMPLETE;
			if (total_ext > htf_pkg::MSG_W'(htf_pkg::VAL_MAX)) begin
				res_d.message_length = htf_pkg::VAL_MAX;
			end else begin
				res_d.message_length = total_ext[htf_pkg::VAL_W-1:0];
			end
		end
	end

	// message state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q    <= '0;
			tp_q    <= 2'd0;
			hd_q    <= 1'b0;
			total_q <= '0;
			kp_q    <= '0;
			ph_q    <= htf_pkg::PH_SEARCH;
			lv_q    <= '0;
		end else begin
			bc_q    <= bc_n;
			tp_q    <= tp_n;
			hd_q    <= hd_n;
			total_q <= total_n;
			kp_q    <= kp_n;
			ph_q    <= ph_n;
			if (take) begin
				lv_q <= (cls.restart || complete) ? '0 : lv_n;
			end
		end
	end

	// result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wptr_q  <= 1'b0;
			res_rptr_q  <= 1'b0;
			res_count_q <= 2'd0;
		end else begin
			if (take) begin
				res_wptr_q <= ~res_wptr_q;
			end
			if (res_pop) begin
				res_rptr_q <= ~res_rptr_q;
			end
			if (take && !res_pop) begin
				res_count_q <= res_count_q + 2'd1;
			end else if (res_pop && !take) begin
				res_count_q <= res_count_q - 2'd1;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (take) begin
			res_mem_q[res_wptr_q] <= res_d;
		end
	end

endmodule

[src/http_request_framer.sv]
// ----------------------------------------------------------------------------
// http_request_framer
// An accepted byte is classified into the class queue; the back end takes it
// from there and writes its result beat into the result queue for popping.
// Throughput: one byte per cycle while the result queue has room and the
// class queue holds a byte; both queues are two entries deep.
// Reset: arst_n clears all message state and both queues and loads
// header_limit 8192 and body_limit 1048576.
// Finds the end of each request from the header terminator and the
// content-length field, and flags requests that run past the size limits.
// ----------------------------------------------------------------------------
module http_request_framer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  htf_pkg::request_t           request,
	output logic                        full,
	input  logic                        pop,
	output logic                        empty,
	output htf_pkg::result_t            result,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [htf_pkg::BLIM_W-1:0]  wr_data
);

	logic [htf_pkg::HLIM_W-1:0]  header_limit_q;
	logic [htf_pkg::BLIM_W-1:0]  body_limit_q;
	logic [htf_pkg::LIMIT_W-1:0] limit_q;
	logic [htf_pkg::HLIM_W-1:0]  hlim_eff;

	htf_pkg::class_t             cls_in;
	htf_pkg::class_t             cls_out;
	logic                        cls_empty;
	logic                        cls_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_limit_q <= htf_pkg::DEFAULT_HEADER_LIMIT;
			body_limit_q   <= htf_pkg::DEFAULT_BODY_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				htf_pkg::REG_HEADER_LIMIT: begin
					header_limit_q <= wr_data[htf_pkg::HLIM_W-1:0];
				end
				htf_pkg::REG_BODY_LIMIT: begin
					body_limit_q <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// overflow threshold, a zero header limit acts as the default
	assign hlim_eff = (header_limit_q == '0) ? htf_pkg::DEFAULT_HEADER_LIMIT
			: header_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= htf_pkg::LIMIT_W'(htf_pkg::DEFAULT_HEADER_LIMIT) +
					htf_pkg::LIMIT_W'(htf_pkg::DEFAULT_BODY_LIMIT);
		end else begin
			limit_q <= htf_pkg::LIMIT_W'(hlim_eff) + htf_pkg::LIMIT_W'(body_limit_q);
		end
	end

	// front end
	htf_classify u_classify (
		.request (request),
		.cls     (cls_in)
	);

	// decoupling queue
	htf_class_queue u_class_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cls_in),
		.full   (full),
		.pop    (cls_pop),
		.empty  (cls_empty),
		.dout   (cls_out)
	);

	// back end
	htf_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_out),
		.cls_empty (cls_empty),
		.cls_pop   (cls_pop),
		.limit     (limit_q),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

[tb/tb_http_request_framer.sv]
// ----------------------------------------------------------------------------
// tb_http_request_framer
// Self-checking bench for the request framer. Bytes go in through the push
// side and one result beat per byte comes back through the pop side. A
// behavioural copy of the framer predicts every beat. A short scripted part
// covers terminators, the length field, restarts and the size limits. Random
// requests follow, mostly well formed with random case, spacing, values and
// bodies, mixed with broken fragments, noise and restarts, under several
// limit settings. Both sides idle at random, and the pop side also holds off
// long enough for the framer to fill up.
// ----------------------------------------------------------------------------
module tb_http_request_framer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT     = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 260;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 100000;

	localparam logic [7:0] ASCII_CR = 8'h0D;
	localparam logic [7:0] ASCII_LF = 8'h0A;
	localparam logic [7:0] ASCII_SP = 8'h20;
	localparam logic [7:0] ASCII_0  = 8'h30;
	localparam logic [7:0] ASCII_9  = 8'h39;
	localparam logic [7:0] ASCII_A  = 8'h41;
	localparam logic [7:0] ASCII_Z  = 8'h5A;
	localparam logic [7:0] ASCII_LA = 8'h61;
	localparam logic [7:0] ASCII_LZ = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam logic [63:0] HDR_LIMIT_FALLBACK = 64'd8192;
	localparam logic [63:0] COUNT_TOP          = 64'hFFFF_FFFF;
	localparam htf_pkg::result_t QUIET_BEAT    = {htf_pkg::STATUS_MORE, 32'd0, 32'd0};

	typedef enum logic [1:0] {
		ROW_TEXT,
		ROW_BYTE,
		ROW_RESTART,
		ROW_WRITE
	} row_op_t;

	typedef struct {
		row_op_t                    op;
		string                      text;
		logic [htf_pkg::BLIM_W-1:0] value;
		logic                       idx;
		bit                         typed;
		htf_pkg::result_t           want;
	} script_row_t;

	// dut signals
	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       push;
	htf_pkg::request_t          request;
	logic                       full;
	logic                       pop;
	logic                       empty;
	htf_pkg::result_t           result;
	logic                       wr_en;
	logic                       wr_index;
	logic [htf_pkg::BLIM_W-1:0] wr_data;

	// framer copy: limits and message state
	logic [htf_pkg::HLIM_W-1:0] cfg_hlimit;
	logic [htf_pkg::BLIM_W-1:0] cfg_blimit;
	logic [31:0]                msg_count;
	logic [1:0]                 crlf_pos;
	bit                         hdr_done;
	logic [31:0]                hdr_len;
	int                         key_pos;
	htf_pkg::phase_t            len_phase;
	logic [31:0]                len_value;
	string                      length_key = "content-length:";

	// bench bookkeeping
	htf_pkg::result_t  expected_frames [$];
	htf_pkg::request_t outgoing [$];
	int       items_sent   = 0;
	int       errors       = 0;
	int       cycle_count  = 0;
	int       holds_asked  = 0;
	bit       calm         = 1'b0;

	// scripted part, expectation typed in on the last beat of a row
	script_row_t script [19] = '{
		'{ROW_BYTE,    "", 25'h00, htf_pkg::REG_HEADER_LIMIT, 1'b1, QUIET_BEAT},
		'{ROW_BYTE,    "", 25'hFF, htf_pkg::REG_HEADER_LIMIT, 1'b1, QUIET_BEAT},
		'{ROW_RESTART, "", 25'h00, htf_pkg::REG_HEADER_LIMIT, 1'b1, QUIET_BEAT},
		'{ROW_TEXT, "\015\012\015\012", 25'h0, htf_pkg::REG_HEADER_LIMIT, 1'b1,
			{htf_pkg::STATUS_COMPLETE, 32'd4, 32'd0}},
		'{ROW_TEXT, "Content-Length: x5\015\012\015\012", 25'h0,
			htf_pkg::REG_HEADER_LIMIT, 1'b1,
			{htf_pkg::STATUS_COMPLETE, 32'd22, 32'd0}},
		'{ROW_TEXT, "content-length: 99999999999", 25'h0,
			htf_pkg::REG_HEADER_LIMIT, 1'b1,
			{htf_pkg::STATUS_MORE, 32'd0, 32'hFFFF_FFFF}},
		'{ROW_RESTART, "", 25'h00, htf_pkg::REG_HEADER_LIMIT, 1'b1, QUIET_BEAT},
		'{ROW_TEXT, "CONTENT-LENGTH:7\015\012content-length: 3\015\012\015\012", 25'h0,
			htf_pkg::REG_HEADER_LIMIT, 1'b1, {htf_pkg::STATUS_MORE, 32'd0, 32'd7}},
		'{ROW_TEXT, "ab cdef", 25'h0, htf_pkg::REG_HEADER_LIMIT, 1'b1,
			{htf_pkg::STATUS_COMPLETE, 32'd46, 32'd7}},
		'{ROW_WRITE,   "", 25'd1, htf_pkg::REG_HEADER_LIMIT, 1'b0, QUIET_BEAT},
		'{ROW_WRITE,   "", 25'd0, htf_pkg::REG_BODY_LIMIT,   1'b0, QUIET_BEAT},
		'{ROW_TEXT, "ab", 25'h0, htf_pkg::REG_HEADER_LIMIT, 1'b1,
			{htf_pkg::STATUS_TOO_LARGE, 32'd0, 32'd0}},
		'{ROW_BYTE, "", 25'h0D, htf_pkg::REG_HEADER_LIMIT, 1'b1,
			{htf_pkg::STATUS_TOO_LARGE, 32'd0, 32'd0}},
		'{ROW_RESTART, "", 25'h00, htf_pkg::REG_HEADER_LIMIT, 1'b1, QUIET_BEAT},
		'{ROW_WRITE,   "", 25'd0, htf_pkg::REG_HEADER_LIMIT, 1'b0, QUIET_BEAT},
		'{ROW_TEXT, "ab\015\012\015\012", 25'h0, htf_pkg::REG_HEADER_LIMIT, 1'b1,
			{htf_pkg::STATUS_COMPLETE, 32'd6, 32'd0}},
		'{ROW_WRITE,   "", 25'h1FF_FFFF, htf_pkg::REG_HEADER_LIMIT, 1'b0, QUIET_BEAT},
		'{ROW_WRITE,   "", 25'h1FF_FFFF, htf_pkg::REG_BODY_LIMIT,   1'b0, QUIET_BEAT},
		'{ROW_TEXT, "\015\012\015\012", 25'h0, htf_pkg::REG_HEADER_LIMIT, 1'b1,
			{htf_pkg::STATUS_COMPLETE, 32'd4, 32'd0}}
	};

	http_request_framer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.request  (request),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("http_request_framer test failed");
			$finish;
		end
	end

	// clear message state, limits kept
	function automatic void forget_message();
		msg_count = '0;
		crlf_pos  = 2'd0;
		hdr_done  = 1'b0;
		hdr_len   = '0;
		key_pos   = 0;
		len_phase = htf_pkg::PH_SEARCH;
		len_value = '0;
	endfunction

	// one byte or restart through the framer copy
	function automatic htf_pkg::result_t advance_framer(htf_pkg::request_t item);
		htf_pkg::result_t res;
		logic [7:0]  b;
		logic [7:0]  lc;
		logic [63:0] wide;
		logic [63:0] hlim;
		logic [63:0] total;
		int          p;
		res = QUIET_BEAT;
		b   = item.byte_value;
		if (item.kind == htf_pkg::KIND_RESTART) begin
			forget_message();
			return res;
		end
		if (64'(msg_count) != COUNT_TOP)
			msg_count++;
		if (!hdr_done) begin
			// length field: keyword hunt, then spaces, then digits
			lc = (b >= ASCII_A && b <= ASCII_Z) ? b + CASE_GAP : b;
			if (len_phase == htf_pkg::PH_SEARCH) begin
				p = key_pos;
				if (p < length_key.len() && lc == length_key[p])
					p++;
				else
					p = (lc == length_key[0]) ? 1 : 0;
				if (p >= length_key.len()) begin
					key_pos   = 0;
					len_phase = htf_pkg::PH_SKIP;
				end else begin
					key_pos = p;
				end
			end else if (len_phase != htf_pkg::PH_FINISHED) begin
				if (b >= ASCII_0 && b <= ASCII_9) begin
					wide      = 64'(len_value) * 64'd10 + 64'(b - ASCII_0);
					len_value = (wide > COUNT_TOP) ? 32'hFFFF_FFFF : wide[31:0];
					len_phase = htf_pkg::PH_DIGITS;
				end else if (!(b == ASCII_SP && len_phase == htf_pkg::PH_SKIP)) begin
					len_phase = htf_pkg::PH_FINISHED;
				end
			end
			// blank line hunt
			if (b == ASCII_CR) begin
				crlf_pos = (crlf_pos == 2'd2) ? 2'd3 : 2'd1;
			end else if (b == ASCII_LF && crlf_pos == 2'd1) begin
				crlf_pos = 2'd2;
			end else if (b == ASCII_LF && crlf_pos == 2'd3) begin
				crlf_pos = 2'd0;
				hdr_done = 1'b1;
				hdr_len  = msg_count;
			end else begin
				crlf_pos = 2'd0;
			end
		end
		// size limit wins over completion
		hlim = (cfg_hlimit == '0) ? HDR_LIMIT_FALLBACK : 64'(cfg_hlimit);
		if (64'(msg_count) > hlim + 64'(cfg_blimit)) begin
			res.status      = htf_pkg::STATUS_TOO_LARGE;
			res.body_length = len_value;
			return res;
		end
		if (hdr_done) begin
			total = 64'(hdr_len) + 64'(len_value);
			if (total > COUNT_TOP)
				total = COUNT_TOP;
			if (64'(msg_count) >= total) begin
				res.status         = htf_pkg::STATUS_COMPLETE;
				res.message_length = total[31:0];
				res.body_length    = len_value;
				forget_message();
				return res;
			end
		end
		res.body_length = len_value;
		return res;
	endfunction

	// one beat into the framer, prediction taken at the accepting edge
	task automatic send_item(htf_pkg::request_t item, bit typed, htf_pkg::result_t want);
		htf_pkg::result_t predicted;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push    <= 1'b1;
		request <= item;
		do @(posedge clk); while (full);
		predicted = advance_framer(item);
		expected_frames.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// stop offering and wait for every result beat
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [htf_pkg::BLIM_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == htf_pkg::REG_HEADER_LIMIT)
			cfg_hlimit = data[htf_pkg::HLIM_W-1:0];
		else
			cfg_blimit = data;
	endtask

	// request builders
	task automatic put_byte(logic [7:0] b);
		htf_pkg::request_t item;
		item.kind       = htf_pkg::KIND_DATA;
		item.byte_value = b;
		outgoing.push_back(item);
	endtask

	task automatic put_restart();
		htf_pkg::request_t item;
		item.kind       = htf_pkg::KIND_RESTART;
		item.byte_value = 8'($urandom_range(0, 255));
		outgoing.push_back(item);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_crlf();
		put_byte(ASCII_CR);
		put_byte(ASCII_LF);
	endtask

	// keyword prefix with letters in random case
	task automatic put_keyword(int upto);
		logic [7:0] c;
		for (int i = 0; i < upto; i++) begin
			c = length_key[i];
			if (c >= ASCII_LA && c <= ASCII_LZ && $urandom_range(0, 1) == 1)
				c = c - CASE_GAP;
			put_byte(c);
		end
	endtask

	task automatic queue_request();
		int          flavour;
		int          body;
		logic [31:0] value;
		bit          huge;
		flavour = $urandom_range(0, 99);
		value   = '0;
		huge    = 1'b0;
		if (flavour < 70) begin
			// request line, a few plain fields, maybe a length field, body
			repeat ($urandom_range(3, 12)) put_byte(8'($urandom_range(33, 126)));
			put_crlf();
			repeat ($urandom_range(0, 2)) begin
				put_text("x-");
				repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(97, 122)));
				put_text(": ");
				repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(32, 126)));
				put_crlf();
			end
			if ($urandom_range(0, 3) != 0) begin
				put_keyword(length_key.len());
				repeat ($urandom_range(0, 2)) put_byte(ASCII_SP);
				if ($urandom_range(0, 15) == 0) begin
					huge = 1'b1;
					repeat ($urandom_range(10, 12))
						put_byte(ASCII_0 + 8'($urandom_range(0, 9)));
				end else begin
					value = $urandom_range(0, 40);
					if ($urandom_range(0, 5) == 0)
						put_byte(ASCII_0);
					put_text($sformatf("%0d", value));
				end
				case ($urandom_range(0, 7))
					0: put_text(" 7");
					1: put_text(";x");
					default: ;
				endcase
				put_crlf();
				// a second length field is ignored
				if ($urandom_range(0, 5) == 0) begin
					put_keyword(length_key.len());
					put_text(" 9");
					put_crlf();
				end
			end
			put_crlf();
			body = huge ? $urandom_range(0, 20) : int'(value);
			repeat (body) put_byte(8'($urandom_range(0, 255)));
			if (huge)
				put_restart();
		end else if (flavour < 80) begin
			// broken keyword or terminator, often abandoned
			put_keyword($urandom_range(1, length_key.len() - 1));
			put_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 1) begin
				put_crlf();
				put_byte(ASCII_CR);
			end
			repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 1)
				put_restart();
		end else if (flavour < 92) begin
			// noise rich in line breaks
			repeat ($urandom_range(1, 16)) begin
				case ($urandom_range(0, 3))
					0: put_byte(ASCII_CR);
					1: put_byte(ASCII_LF);
					default: put_byte(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			put_restart();
		end
	endtask

	// one limit setting, then random requests
	task automatic run_phase(logic [htf_pkg::BLIM_W-1:0] hdr,
			logic [htf_pkg::BLIM_W-1:0] body, bit quiet, bit squeeze);
		int goal;
		drain_results();
		write_reg(htf_pkg::REG_HEADER_LIMIT, hdr);
		write_reg(htf_pkg::REG_BODY_LIMIT, body);
		calm = quiet;
		if (squeeze)
			holds_asked++;
		goal = items_sent + PHASE_ITEMS;
		while (items_sent < goal) begin
			queue_request();
			foreach (outgoing[i])
				send_item(outgoing[i], 1'b0, QUIET_BEAT);
			outgoing.delete();
		end
	endtask

	// pop side: random idling and long hold-offs
	initial begin : pop_side
		int stall_left;
		int holds_served;
		stall_left   = 0;
		holds_served = 0;
		pop = 1'b0;
		while (arst_n !== 1'b1)
			@(negedge clk);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (holds_served != holds_asked) begin
				holds_served++;
				stall_left = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// result beat check against the oldest prediction
	always @(posedge clk) begin : check_results
		htf_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected result beat, status %0d length %0d body %0d",
					$time, result.status, result.message_length, result.body_length);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d got %0d",
						$time, want.status, result.status);
					errors++;
				end
				if (result.message_length !== want.message_length) begin
					$display("%0t: message_length expected %0d got %0d",
						$time, want.message_length, result.message_length);
					errors++;
				end
				if (result.body_length !== want.body_length) begin
					$display("%0t: body_length expected %0d got %0d",
						$time, want.body_length, result.body_length);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		htf_pkg::request_t item;
		arst_n   = 1'b0;
		push     = 1'b0;
		request  = '0;
		wr_en    = 1'b0;
		wr_index = htf_pkg::REG_HEADER_LIMIT;
		wr_data  = '0;
		cfg_hlimit = htf_pkg::HLIM_W'(8192);
		cfg_blimit = htf_pkg::BLIM_W'(1048576);
		forget_message();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// scripted rows
		foreach (script[i]) begin
			case (script[i].op)
				ROW_WRITE: begin
					drain_results();
					write_reg(script[i].idx, script[i].value);
				end
				ROW_RESTART: begin
					item.kind       = htf_pkg::KIND_RESTART;
					item.byte_value = 8'h00;
					send_item(item, script[i].typed, script[i].want);
				end
				ROW_BYTE: begin
					item.kind       = htf_pkg::KIND_DATA;
					item.byte_value = script[i].value[7:0];
					send_item(item, script[i].typed, script[i].want);
				end
				default: begin
					for (int j = 0; j < script[i].text.len(); j++) begin
						item.kind       = htf_pkg::KIND_DATA;
						item.byte_value = script[i].text[j];
						send_item(item, script[i].typed && j == script[i].text.len() - 1,
							script[i].want);
					end
				end
			endcase
		end

		// random requests under several limit settings
		run_phase(htf_pkg::BLIM_W'(8192), htf_pkg::BLIM_W'(1048576), 1'b1, 1'b0);
		run_phase(25'h1FF_FFFF, 25'h1FF_FFFF, 1'b0, 1'b0);
		run_phase({4'($urandom_range(0, 15)), 21'($urandom_range(20, 120))},
			25'($urandom_range(0, 80)), 1'b0, 1'b1);
		run_phase(25'd0, 25'd0, 1'b0, 1'b0);
		run_phase(25'd1, 25'd0, 1'b0, 1'b0);
		run_phase(25'($urandom), 25'($urandom), 1'b0, 1'b0);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("http_request_framer test passed");
		else
			$display("http_request_framer test failed");
		$finish;
	end

endmodule
